@@ hw/rtl/kpwd_pkg.sv @@
package kpwd_pkg;

    // Word storage: first received bit lands in bit 63
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 7;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_val;

    localparam t_cfg_idx CFG_KEYPAD_GAP = 1'd0;
    localparam t_cfg_idx CFG_PANEL_GAP  = 1'd1;

    localparam t_cfg_val KEYPAD_GAP_RST = 16'd14800;
    localparam t_cfg_val PANEL_GAP_RST  = 16'd15200;

    // Minimum panel word length that can be ended
    localparam t_count MIN_PANEL_BITS = 7'd8;

    // Panel commands
    localparam logic [7:0] CMD_STATUS  = 8'h05;
    localparam logic [7:0] CMD_DATE    = 8'ha5;
    localparam logic [7:0] CMD_ZONE_A  = 8'h27;
    localparam logic [7:0] CMD_ZONE_B  = 8'h2d;
    localparam logic [7:0] CMD_ZONE_C  = 8'h34;
    localparam logic [7:0] CMD_ZONE_D  = 8'h3e;

    // User code conversion constants
    localparam logic [7:0] USER_ARM2_OFS = 8'h19;
    localparam logic [7:0] USER_SKIP_THR = 8'd34;
    localparam logic [7:0] USER_SKIP_ADD = 8'd5;

    // One ended panel word together with the keypad word saved at that point
    typedef struct packed {
        t_word  panel_word;
        t_count panel_len;
        t_word  key_word;
        t_count key_len;
    } t_job;

    // One decoded result
    typedef struct packed {
        logic        keypad_valid;
        logic [7:0]  keypad_cmd;
        logic [7:0]  keypad_byte2;
        logic        panel_new;
        logic [7:0]  panel_cmd;
        logic [6:0]  status_flags;
        logic [7:0]  zone_bits;
        logic [27:0] time_packed;
        logic [10:0] arm_info;
        logic        checksum_ok;
        t_word       panel_word;
        t_count      panel_length;
    } t_result;

endpackage

@@ hw/rtl/kpwd_front.sv @@
module kpwd_front
    import kpwd_pkg::*;
#(
    parameter int WORD_LIMIT = 63
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_cfg_val i_cfg_data,
    input  logic     i_valid,
    input  logic     i_edge_rising,
    input  logic     i_data_bit,
    input  logic [15:0] i_gap_us,
    output logic     o_ready,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_ready
);

    localparam t_count LIMIT_CNT = t_count'(WORD_LIMIT);

    t_cfg_val r_keypad_gap, r_panel_gap;
    t_word    r_panel_shift, n_panel_shift;
    t_count   r_panel_count, n_panel_count;
    t_word    r_key_shift, n_key_shift;
    t_count   r_key_count, n_key_count;
    t_word    r_key_saved, n_key_saved;
    t_count   r_key_saved_count, n_key_saved_count;

    logic   accept;
    logic   kp_save;
    logic   pn_end;
    t_word  panel_base, key_base;
    t_count panel_base_cnt, key_base_cnt;
    logic   panel_room, key_room;

    assign o_ready = i_job_ready;
    assign accept  = i_valid && i_job_ready;

    // Classify the edge by its gap
    assign kp_save = (i_gap_us > r_keypad_gap);
    assign pn_end  = (i_gap_us >= r_panel_gap) && (r_panel_count >= MIN_PANEL_BITS);

    // Start from a cleared word where the gap restarts it
    assign key_base       = kp_save ? '0 : r_key_shift;
    assign key_base_cnt   = kp_save ? '0 : r_key_count;
    assign panel_base     = pn_end ? '0 : r_panel_shift;
    assign panel_base_cnt = pn_end ? '0 : r_panel_count;

    assign key_room   = (key_base_cnt <= LIMIT_CNT);
    assign panel_room = (panel_base_cnt <= LIMIT_CNT);

    // Shift the edge's bit into its word; a full word drops it
    always_comb begin
        n_panel_shift     = r_panel_shift;
        n_panel_count     = r_panel_count;
        n_key_shift       = r_key_shift;
        n_key_count       = r_key_count;
        n_key_saved       = r_key_saved;
        n_key_saved_count = r_key_saved_count;
        if (accept) begin
            if (kp_save) begin
                n_key_saved       = r_key_shift;
                n_key_saved_count = r_key_count;
            end
            n_key_shift   = key_base;
            n_key_count   = key_base_cnt;
            n_panel_shift = panel_base;
            n_panel_count = panel_base_cnt;
            if (i_edge_rising) begin
                if (panel_room) begin
                    n_panel_shift = panel_base
                        | (t_word'(i_data_bit) << (~panel_base_cnt[5:0]));
                    n_panel_count = panel_base_cnt + 7'd1;
                end
            end else begin
                if (key_room) begin
                    n_key_shift = key_base
                        | (t_word'(i_data_bit) << (~key_base_cnt[5:0]));
                    n_key_count = key_base_cnt + 7'd1;
                end
            end
        end
    end

    // Hand the ended word to the decoder
    assign o_job_valid      = accept && pn_end;
    assign o_job.panel_word = r_panel_shift;
    assign o_job.panel_len  = r_panel_count;
    assign o_job.key_word   = kp_save ? r_key_shift : r_key_saved;
    assign o_job.key_len    = kp_save ? r_key_count : r_key_saved_count;

    // Hold configuration and word state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keypad_gap      <= KEYPAD_GAP_RST;
            r_panel_gap       <= PANEL_GAP_RST;
            r_panel_shift     <= '0;
            r_panel_count     <= '0;
            r_key_shift       <= '0;
            r_key_count       <= '0;
            r_key_saved       <= '0;
            r_key_saved_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEYPAD_GAP: r_keypad_gap <= i_cfg_data;
                    CFG_PANEL_GAP:  r_panel_gap  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_panel_shift     <= n_panel_shift;
            r_panel_count     <= n_panel_count;
            r_key_shift       <= n_key_shift;
            r_key_count       <= n_key_count;
            r_key_saved       <= n_key_saved;
            r_key_saved_count <= n_key_saved_count;
        end
    end

endmodule

@@ hw/rtl/kpwd_queue.sv @@
module kpwd_queue
    import kpwd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_data,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    logic       do_push, do_pop;

    assign o_push_ready = (r_fill != 2'd2);
    assign o_pop_valid  = (r_fill != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign do_push = i_push && o_push_ready;
    assign do_pop  = i_pop && o_pop_valid;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_fill   = r_fill + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ hw/rtl/kpwd_back.sv @@
module kpwd_back
    import kpwd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    t_word   r_last_panel;
    t_count  r_last_count;
    logic    r_valid, n_valid;
    t_result r_result, n_result;

    t_word       w;
    logic [7:0]  cmd;
    logic        is_new;
    logic [1:0]  arm;
    logic [7:0]  user;
    logic [7:0]  bytes [6];
    logic [7:0]  psum [6];
    logic [2:0]  groups;
    logic        chk;
    t_word       kmask;
    logic        pop;

    assign w      = i_job.panel_word;
    assign cmd    = w[63:56];
    assign is_new = (cmd != 8'd0)
                 && !((w == r_last_panel) && (i_job.panel_len == r_last_count));

    // Convert the user code of the arming message
    assign arm = w[22:21];
    always_comb begin
        user = {2'b00, w[20:15]};
        if (arm == 2'd2) begin
            user = user - USER_ARM2_OFS;
        end
        if (arm != 2'd0) begin
            user = user + 8'd1;
            if (user > USER_SKIP_THR) begin
                user = user + USER_SKIP_ADD;
            end
        end else begin
            user = 8'd0;
        end
    end

    // Gather full bytes after the separator bit and their running sums
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            bytes[i] = w[54-8*i -: 8];
        end
        psum[0] = cmd;
        for (int i = 1; i < 6; i++) begin
            psum[i] = psum[i-1] + bytes[i-1];
        end
    end

    // Pick the last full byte and check it against the sum before it
    always_comb begin
        groups = 3'd0;
        if (i_job.panel_len > 7'd8) begin
            groups = 3'((i_job.panel_len - 7'd9) >> 3);
        end
        chk = 1'b0;
        if (groups != 3'd0) begin
            chk = (psum[3'(groups - 3'd1)] == bytes[3'(groups - 3'd1)]);
        end
    end

    // Mark the received bits of the saved keypad word
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            kmask[WORD_W-1-i] = (t_count'(i) < i_job.key_len);
        end
    end

    // Assemble the result
    always_comb begin
        n_result              = '0;
        n_result.panel_new    = is_new;
        n_result.panel_cmd    = cmd;
        n_result.checksum_ok  = chk;
        n_result.panel_word   = w;
        n_result.panel_length = i_job.panel_len;
        n_result.keypad_valid = |(~i_job.key_word & kmask);
        n_result.keypad_cmd   = i_job.key_word[63:56];
        n_result.keypad_byte2 = i_job.key_word[55:48];
        if (is_new) begin
            if (cmd == CMD_STATUS) begin
                n_result.status_flags = {w[34], w[46], w[48], w[49], w[50], w[51], w[47]};
            end else if (cmd == CMD_DATE) begin
                n_result.time_packed = {w[54:51], w[50:47], w[44:41], w[40:36],
                                        w[35:31], w[30:25]};
                n_result.arm_info    = {arm, w[20], user};
            end else if (cmd == CMD_ZONE_A || cmd == CMD_ZONE_B ||
                         cmd == CMD_ZONE_C || cmd == CMD_ZONE_D) begin
                n_result.zone_bits = w[22:15];
            end
        end
    end

    // Take the next word whenever the output register is free or draining
    assign pop       = i_job_valid && (!r_valid || i_ready);
    assign o_job_pop = pop;

    always_comb begin
        n_valid = r_valid;
        if (pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_panel <= '0;
            r_last_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (pop && is_new) begin
                r_last_panel <= w;
                r_last_count <= i_job.panel_len;
            end
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/keybus_panel_word_decoder_top.sv @@
// Keybus panel word decoder. Each input transfer is one keybus clock edge; the decoder
// builds the panel word from rising edges and the keypad word from falling edges, and
// a gap of at least panel_gap_us after a panel word of 8 or more bits emits one decoded
// result (command, status flags, zones, date and time, arming info, checksum, raw word
// and the keypad word saved by the last gap above keypad_gap_us). One edge is accepted
// every cycle while o_s_tready is high and taken in by the edge front end; the word
// decoder turns out one result per cycle unless back-pressured, with a two-entry queue
// between them. An ended word goes to the queue, then the output register; o_s_tready
// drops only while the queue is full under output back-pressure. The user must write
// configuration via i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle (not enforced).
module keybus_panel_word_decoder_top
    import kpwd_pkg::*;
#(
    parameter int WORD_LIMIT = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,   // data_bit[0], gap_us[16:1], zero[23:17]
    input  logic          i_s_tuser,   // edge_rising[0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // panel_new[0], panel_cmd[8:1], status_flags[15:9], zone_bits[23:16],
    // time_packed[51:24], arm_info[62:52], checksum_ok[63], panel_word[127:64],
    // panel_length[134:128], keypad_valid[135], keypad_cmd[143:136],
    // keypad_byte2[151:144]
    output logic [151:0]  o_m_tdata
);

    logic    job_valid, job_ready;
    t_job    job;
    logic    q_valid, q_pop;
    t_job    q_job;
    t_result res;

    kpwd_front #(
        .WORD_LIMIT (WORD_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_tvalid),
        .i_edge_rising (i_s_tuser),
        .i_data_bit    (i_s_tdata[0]),
        .i_gap_us      (i_s_tdata[16:1]),
        .o_ready       (o_s_tready),
        .o_job_valid   (job_valid),
        .o_job         (job),
        .i_job_ready   (job_ready)
    );

    kpwd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (job_valid),
        .i_push_data  (job),
        .o_push_ready (job_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_job),
        .i_pop        (q_pop)
    );

    kpwd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_valid     (o_m_tvalid),
        .o_result    (res),
        .i_ready     (i_m_tready)
    );

    // Pack the result, first field lowest
    assign o_m_tdata = {res.keypad_byte2, res.keypad_cmd, res.keypad_valid,
                        res.panel_length, res.panel_word, res.checksum_ok,
                        res.arm_info, res.time_packed, res.zone_bits,
                        res.status_flags, res.panel_cmd, res.panel_new};

endmodule
